[design/atp_pkg.sv]
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types, codes and colour tables of the ANSI text terminal parser.
// ----------------------------------------------------------------------------
package atp_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_SGR
    } t_state;

    // Escape parser states
    typedef enum logic [1:0] {
        PS_TEXT = 2'd0,
        PS_ESC  = 2'd1,
        PS_CSI  = 2'd2
    } t_parse;

    // What a byte does, as seen by the controller
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ONE,
        KIND_TWO,
        KIND_SGR
    } t_kind;

    // Cell command codes on the result channel
    typedef enum logic [1:0] {
        CMD_DRAW         = 2'd0,
        CMD_CLEAR_CELL   = 2'd1,
        CMD_CLEAR_SCREEN = 2'd2,
        CMD_SCROLL       = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        logic load_byte;
        logic exec;
        logic emit_first;
        logic emit_scroll;
        logic sgr_step;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  out_free;
        logic  sgr_last;
    } t_dp_status;

    // Configuration register indexes
    localparam logic REG_COLUMNS   = 1'b0;
    localparam logic REG_TEXT_ROWS = 1'b1;

    localparam logic [7:0] COLUMNS_RESET   = 8'd80;
    localparam logic [6:0] TEXT_ROWS_RESET = 7'd25;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_LBRKT = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;

    // Colours
    localparam logic [23:0] COL_DEFAULT  = 24'he6edf3;
    localparam logic [23:0] PANEL_COLOUR = 24'h101920;
    localparam logic [23:0] WHITE_COLOUR = 24'hffffff;
    localparam logic [23:0] DIM_COLOUR   = 24'h8aa0ad;

    function automatic logic [23:0] normal_colour(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = 24'h1b232b;
            3'd1:    c = 24'hff6b6b;
            3'd2:    c = 24'h68d391;
            3'd3:    c = 24'hf3cc60;
            3'd4:    c = 24'h64b5f6;
            3'd5:    c = 24'hc792ea;
            3'd6:    c = 24'h5fd7e5;
            default: c = 24'he6edf3;
        endcase
        return c;
    endfunction

    function automatic logic [23:0] bright_colour(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = 24'h8aa0ad;
            3'd7:    c = 24'hffffff;
            default: c = normal_colour(idx);
        endcase
        return c;
    endfunction

endpackage

[design/atp_ctrl.sv]
// ----------------------------------------------------------------------------
// atp_ctrl
// Sequencer: takes a byte, executes it, emits results and steps SGR codes.
// ----------------------------------------------------------------------------
module atp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  atp_pkg::t_dp_status  i_status,
    output atp_pkg::t_dp_cmd     o_cmd
);

    atp_pkg::t_state r_state;
    atp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            atp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_byte = 1'b1;
                    n_state         = atp_pkg::ST_EXEC;
                end
            end
            atp_pkg::ST_EXEC: begin
                unique case (i_status.kind)
                    atp_pkg::KIND_NONE: begin
                        o_cmd.exec = 1'b1;
                        n_state    = atp_pkg::ST_IDLE;
                    end
                    atp_pkg::KIND_SGR: begin
                        o_cmd.exec = 1'b1;
                        n_state    = atp_pkg::ST_SGR;
                    end
                    atp_pkg::KIND_ONE: begin
                        // hold until the result register can take the request
                        if (i_status.out_free) begin
                            o_cmd.exec       = 1'b1;
                            o_cmd.emit_first = 1'b1;
                            n_state          = atp_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        if (i_status.out_free) begin
                            o_cmd.exec       = 1'b1;
                            o_cmd.emit_first = 1'b1;
                            n_state          = atp_pkg::ST_SCROLL;
                        end
                    end
                endcase
            end
            atp_pkg::ST_SCROLL: begin
                if (i_status.out_free) begin
                    o_cmd.emit_scroll = 1'b1;
                    n_state           = atp_pkg::ST_IDLE;
                end
            end
            default: begin
                o_cmd.sgr_step = 1'b1;
                if (i_status.sgr_last) begin
                    n_state = atp_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

[design/atp_datapath.sv]
// ----------------------------------------------------------------------------
// atp_datapath
// Cursor, escape parser, parameter slots, colours and the result register.
// ----------------------------------------------------------------------------
module atp_datapath #(
    parameter int PARAM_SLOTS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  atp_pkg::t_dp_cmd     i_cmd,
    output atp_pkg::t_dp_status  o_status,
    input  logic [7:0]           i_byte,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_out_command,
    output logic [7:0]           o_out_col,
    output logic [6:0]           o_out_row,
    output logic [7:0]           o_out_glyph,
    output logic [23:0]          o_out_fore,
    output logic [23:0]          o_out_back,
    output logic                 o_out_last
);

    localparam int CW = $clog2(PARAM_SLOTS + 1);
    localparam int IW = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;

    logic [7:0]       r_byte;
    logic [7:0]       r_col;
    logic [6:0]       r_row;
    atp_pkg::t_parse  r_parse;
    logic [31:0]      r_acc;
    logic [31:0]      r_slots [PARAM_SLOTS];
    logic [CW-1:0]    r_count;
    logic [IW-1:0]    r_sgr_idx;
    logic [23:0]      r_fore;
    logic [23:0]      r_back;
    logic             r_inverse;
    logic [7:0]       r_columns;
    logic [6:0]       r_rows;

    logic             r_out_valid;
    logic [1:0]       r_out_command;
    logic [7:0]       r_out_col;
    logic [6:0]       r_out_row;
    logic [7:0]       r_out_glyph;
    logic [23:0]      r_out_fore;
    logic [23:0]      r_out_back;
    logic             r_out_last;

    // byte execution
    logic [7:0]       n_col;
    logic [6:0]       n_row;
    atp_pkg::t_parse  n_parse;
    logic [31:0]      n_acc;
    logic [CW-1:0]    n_count;
    logic             slot_wr;
    atp_pkg::t_kind   kind;
    logic [1:0]       d_cmd;
    logic [7:0]       d_col;
    logic [6:0]       d_row;
    logic [7:0]       d_glyph;
    logic [23:0]      d_fore;
    logic [23:0]      d_back;
    logic [8:0]       col_inc;
    logic [7:0]       row_inc;
    logic             row_wrap;
    logic [6:0]       nl_row;
    logic [31:0]      acc_mul;
    logic             push;
    logic             geo_ok;

    // SGR step
    logic [31:0]      sgr_p;
    logic             sgr_small;
    logic [6:0]       sgr_v;
    logic             sgr_last;
    logic [23:0]      n_fore;
    logic [23:0]      n_back;
    logic             n_inverse;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_parse = r_parse;
        n_acc   = r_acc;
        push    = 1'b0;
        kind    = atp_pkg::KIND_NONE;
        d_cmd   = atp_pkg::CMD_DRAW;
        d_col   = '0;
        d_row   = '0;
        d_glyph = '0;
        d_fore  = '0;
        d_back  = '0;

        geo_ok   = (r_columns != 8'd0) && (r_rows != 7'd0);
        col_inc  = {1'b0, r_col} + 9'd1;
        row_inc  = {1'b0, r_row} + 8'd1;
        row_wrap = row_inc >= {1'b0, r_rows};
        nl_row   = row_wrap ? (r_rows - 7'd1) : row_inc[6:0];
        acc_mul  = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, r_byte[3:0]};

        if (!geo_ok) begin
            kind = atp_pkg::KIND_NONE;
        end else if (r_parse == atp_pkg::PS_ESC) begin
            if (r_byte == atp_pkg::CH_LBRKT) begin
                n_parse = atp_pkg::PS_CSI;
            end else begin
                n_parse = atp_pkg::PS_TEXT;
            end
            n_acc = '0;
        end else if (r_parse != atp_pkg::PS_TEXT) begin
            if (r_byte >= atp_pkg::CH_0 && r_byte <= atp_pkg::CH_9) begin
                n_acc = acc_mul;
            end else if (r_byte == atp_pkg::CH_SEMI) begin
                push = 1'b1;
            end else if (r_byte == atp_pkg::CH_J) begin
                n_col   = '0;
                n_row   = '0;
                n_parse = atp_pkg::PS_TEXT;
                n_acc   = '0;
                kind    = atp_pkg::KIND_ONE;
                d_cmd   = atp_pkg::CMD_CLEAR_SCREEN;
                d_back  = atp_pkg::PANEL_COLOUR;
            end else if (r_byte == atp_pkg::CH_H) begin
                n_col   = '0;
                n_row   = '0;
                n_parse = atp_pkg::PS_TEXT;
                n_acc   = '0;
            end else if (r_byte == atp_pkg::CH_M) begin
                // count clears when the SGR walk ends
                push    = 1'b1;
                n_parse = atp_pkg::PS_TEXT;
                kind    = atp_pkg::KIND_SGR;
            end else begin
                n_parse = atp_pkg::PS_TEXT;
                n_acc   = '0;
            end
        end else begin
            if (r_byte == atp_pkg::CH_ESC) begin
                n_parse = atp_pkg::PS_ESC;
            end else if (r_byte == atp_pkg::CH_CR) begin
                kind = atp_pkg::KIND_NONE;
            end else if (r_byte == atp_pkg::CH_LF) begin
                n_col  = '0;
                n_row  = nl_row;
                kind   = row_wrap ? atp_pkg::KIND_ONE : atp_pkg::KIND_NONE;
                d_cmd  = atp_pkg::CMD_SCROLL;
                d_back = atp_pkg::PANEL_COLOUR;
            end else if (r_byte == atp_pkg::CH_BS) begin
                n_col  = (r_col != 8'd0) ? (r_col - 8'd1) : 8'd0;
                kind   = atp_pkg::KIND_ONE;
                d_cmd  = atp_pkg::CMD_CLEAR_CELL;
                d_col  = n_col;
                d_row  = r_row;
                d_back = r_back;
            end else begin
                d_cmd   = atp_pkg::CMD_DRAW;
                d_col   = r_col;
                d_row   = r_row;
                d_glyph = r_byte;
                d_fore  = r_inverse ? r_back : r_fore;
                d_back  = r_inverse ? r_fore : r_back;
                if (col_inc >= {1'b0, r_columns}) begin
                    n_col = '0;
                    n_row = nl_row;
                    kind  = row_wrap ? atp_pkg::KIND_TWO : atp_pkg::KIND_ONE;
                end else begin
                    n_col = col_inc[7:0];
                    kind  = atp_pkg::KIND_ONE;
                end
            end
        end

        n_count = r_count;
        slot_wr = 1'b0;
        if (push) begin
            n_acc = '0;
            // drop values beyond the last slot
            if (r_count < CW'(PARAM_SLOTS)) begin
                slot_wr = 1'b1;
                n_count = r_count + CW'(1);
            end
        end else if (r_parse == atp_pkg::PS_ESC || n_parse == atp_pkg::PS_TEXT) begin
            n_count = '0;
        end
    end

    always_comb begin
        sgr_p     = r_slots[r_sgr_idx];
        sgr_small = (sgr_p[31:7] == 25'd0);
        sgr_v     = sgr_p[6:0];
        sgr_last  = (CW'(r_sgr_idx) + CW'(1)) == r_count;
        n_fore    = r_fore;
        n_back    = r_back;
        n_inverse = r_inverse;
        if (sgr_p == 32'd0) begin
            n_fore    = atp_pkg::COL_DEFAULT;
            n_back    = atp_pkg::PANEL_COLOUR;
            n_inverse = 1'b0;
        end else if (sgr_p == 32'd1) begin
            n_fore = atp_pkg::WHITE_COLOUR;
        end else if (sgr_p == 32'd2) begin
            n_fore = atp_pkg::DIM_COLOUR;
        end else if (sgr_p == 32'd7) begin
            n_inverse = 1'b1;
        end else if (sgr_p == 32'd22 || sgr_p == 32'd27) begin
            n_inverse = 1'b0;
        end else if (sgr_small && sgr_v >= 7'd30 && sgr_v <= 7'd37) begin
            n_fore = atp_pkg::normal_colour(3'(sgr_v - 7'd30));
        end else if (sgr_small && sgr_v >= 7'd90 && sgr_v <= 7'd97) begin
            n_fore = atp_pkg::bright_colour(3'(sgr_v - 7'd90));
        end else if (sgr_small && sgr_v >= 7'd40 && sgr_v <= 7'd47) begin
            n_back = atp_pkg::normal_colour(3'(sgr_v - 7'd40));
        end else if (sgr_small && sgr_v >= 7'd100 && sgr_v <= 7'd107) begin
            n_back = atp_pkg::bright_colour(3'(sgr_v - 7'd100));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_parse   <= atp_pkg::PS_TEXT;
            r_acc     <= '0;
            r_count   <= '0;
            r_sgr_idx <= '0;
            r_fore    <= atp_pkg::COL_DEFAULT;
            r_back    <= atp_pkg::PANEL_COLOUR;
            r_inverse <= 1'b0;
            r_columns <= atp_pkg::COLUMNS_RESET;
            r_rows    <= atp_pkg::TEXT_ROWS_RESET;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == atp_pkg::REG_COLUMNS) begin
                    r_columns <= i_cfg_data;
                end else begin
                    r_rows <= i_cfg_data[6:0];
                end
            end
            if (i_cmd.exec) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_parse <= n_parse;
                r_acc   <= n_acc;
                r_count <= n_count;
            end
            if (i_cmd.sgr_step) begin
                r_fore    <= n_fore;
                r_back    <= n_back;
                r_inverse <= n_inverse;
                if (sgr_last) begin
                    r_sgr_idx <= '0;
                    r_count   <= '0;
                end else begin
                    r_sgr_idx <= r_sgr_idx + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_byte;
        end
        if (i_cmd.exec && slot_wr) begin
            r_slots[r_count[IW-1:0]] <= r_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_first || i_cmd.emit_scroll) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_first) begin
            r_out_command <= d_cmd;
            r_out_col     <= d_col;
            r_out_row     <= d_row;
            r_out_glyph   <= d_glyph;
            r_out_fore    <= d_fore;
            r_out_back    <= d_back;
            r_out_last    <= (kind == atp_pkg::KIND_ONE);
        end else if (i_cmd.emit_scroll) begin
            r_out_command <= atp_pkg::CMD_SCROLL;
            r_out_col     <= '0;
            r_out_row     <= '0;
            r_out_glyph   <= '0;
            r_out_fore    <= '0;
            r_out_back    <= atp_pkg::PANEL_COLOUR;
            r_out_last    <= 1'b1;
        end
    end

    assign o_status.kind     = kind;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.sgr_last = sgr_last;

    assign o_out_valid   = r_out_valid;
    assign o_out_command = r_out_command;
    assign o_out_col     = r_out_col;
    assign o_out_row     = r_out_row;
    assign o_out_glyph   = r_out_glyph;
    assign o_out_fore    = r_out_fore;
    assign o_out_back    = r_out_back;
    assign o_out_last    = r_out_last;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_first || i_cmd.emit_scroll) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PARAM_SLOTS))
        else $error("parameter count beyond slot count");

    // the SGR walk only runs over stored parameters and leaves the count clear
    a_sgr_has_params: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sgr_step |-> (r_count != '0))
        else $error("SGR step with no stored parameter");

    a_sgr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sgr_step && sgr_last) |=> (r_count == '0 && r_sgr_idx == '0))
        else $error("SGR walk did not clear its count");

endmodule

[design/ansi_text_terminal_parser_core.sv]
// ----------------------------------------------------------------------------
// ansi_text_terminal_parser_core
// Character stream in, terminal cell commands (draw, clear, scroll) out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one text byte per request. m_axis_* carries cell commands:
//   tuser holds the command code, tdata the cell position, glyph and colours,
//   tlast marks the final command that a byte causes (a byte causes 0 to 2).
//   i_cfg_* writes the column count (index 0) and row count (index 1), always
//   ready; the user writes it only while the block is idle, unchecked here.
// Sequence:
//   A byte is accepted in the idle state, then executed against the cursor and
//   parser state in the execute state. A printable byte that wraps off the
//   bottom row goes on to the scroll state for its scroll command. ESC[...m
//   goes on to the SGR state, which applies the stored SGR codes one a cycle.
// Reset (i_rst_n low, synchronous) homes the cursor, returns the parser to
// text, restores the default colours and geometry 80 x 25.
// When the receiver stalls, the command waits in the output register; the
// next byte is still accepted and held until that register frees up.
// ----------------------------------------------------------------------------
module ansi_text_terminal_parser_core #(
    parameter int PARAM_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] cell_col, [14:8] cell_row, [22:15] glyph, [46:23] fore_rgb,
    // [70:47] back_rgb, [71] zero
    output logic [71:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] command
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    atp_pkg::t_dp_cmd    cmd;
    atp_pkg::t_dp_status status;
    logic [7:0]          out_col;
    logic [6:0]          out_row;
    logic [7:0]          out_glyph;
    logic [23:0]         out_fore;
    logic [23:0]         out_back;

    atp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    atp_datapath #(
        .PARAM_SLOTS (PARAM_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_byte        (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_command (m_axis_tuser),
        .o_out_col     (out_col),
        .o_out_row     (out_row),
        .o_out_glyph   (out_glyph),
        .o_out_fore    (out_fore),
        .o_out_back    (out_back),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_back, out_fore, out_glyph, out_row, out_col};
    assign o_cfg_ready  = 1'b1;

endmodule
